// ===== rtl/aiff_stream_parser_top_macros.svh =====
// Assertion macros for the AIFF stream parser.
`ifndef AIFF_STREAM_PARSER_TOP_MACROS_SVH
`define AIFF_STREAM_PARSER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define AIFFSP_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aiffsp assertion failed");

// Next-cycle implication
`define AIFFSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aiffsp next-cycle assertion failed");

`else

`define AIFFSP_ASSERT(label, clk, rst_n, ante, cons)
`define AIFFSP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/aiffsp_pkg.sv =====
package aiffsp_pkg;

    localparam logic [31:0] TAG_FORM = 32'h464F524D;
    localparam logic [31:0] TAG_AIFF = 32'h41494646;
    localparam logic [31:0] TAG_COMM = 32'h434F4D4D;
    localparam logic [31:0] TAG_SSND = 32'h53534E44;

    localparam logic [31:0] COMM_STD_LEN = 32'd18;
    localparam logic [14:0] RATE_BIAS    = 15'd16414;
    localparam logic [15:0] MIN_BITS     = 16'd8;
    localparam logic [15:0] MAX_BITS     = 16'd24;
    localparam logic [31:0] SSND_HDR_LEN = 32'd8;

    localparam int          CFG_INDEX_W      = 8;
    localparam logic [7:0]  CFG_EXP_CHANNELS = 8'd0;
    localparam logic [7:0]  CFG_EXP_RATE     = 8'd1;

    typedef enum logic [4:0] {
        PH_FORM, PH_FORMLEN, PH_AIFF, PH_ID, PH_LEN, PH_SKIP, PH_COMMLEN, PH_CHAN,
        PH_FRAMES, PH_BITS, PH_EXP, PH_MANT, PH_MANTLO, PH_SSNDLEN, PH_OFFBLK,
        PH_DATA, PH_DONE, PH_HALT
    } phase_t;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_FORMAT = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_NO_FORM     = 3'd1,
        ERR_NOT_AIFF    = 3'd2,
        ERR_CHANNELS    = 3'd3,
        ERR_BITS        = 3'd4,
        ERR_DATA_EARLY  = 3'd5
    } err_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [23:0] sample;
        logic [1:0]         sample_bytes;
        logic [31:0]        file_rate;
        logic               rate_mismatch;
        err_t               error_code;
        logic               last;
    } res_t;

    // Bytes in the header field collected in each phase
    function automatic logic [3:0] field_len(phase_t ph);
        logic [3:0] n;
        case (ph)
            PH_FORM, PH_FORMLEN, PH_AIFF, PH_ID, PH_LEN, PH_COMMLEN,
            PH_FRAMES, PH_MANT, PH_MANTLO, PH_SSNDLEN: n = 4'd4;
            PH_CHAN, PH_BITS, PH_EXP:                  n = 4'd2;
            PH_OFFBLK:                                 n = 4'd8;
            default:                                   n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

// ===== rtl/aiffsp_rate_dec.sv =====
// Round the 80-bit extended rate (sign/exponent word plus top mantissa word)
// to an unsigned integer, saturating at the top.
module aiffsp_rate_dec (
    input  logic [15:0] exponent,
    input  logic [31:0] mantissa,
    output logic [31:0] rate
);

    logic [14:0] exp_mag;
    logic [14:0] up_sh;
    logic [14:0] dn_sh;
    logic [63:0] wide;
    logic [32:0] rounded;

    assign exp_mag = exponent[14:0];
    assign up_sh   = exp_mag - aiffsp_pkg::RATE_BIAS;
    assign dn_sh   = aiffsp_pkg::RATE_BIAS - exp_mag;
    assign wide    = {32'd0, mantissa} << up_sh[5:0];
    assign rounded = ({1'b0, mantissa} + (33'd1 << (dn_sh[5:0] - 6'd1))) >> dn_sh[5:0];

    always_comb
    begin
        if (exponent[15])
        begin
            rate = 32'd0;
        end
        else if (exp_mag >= aiffsp_pkg::RATE_BIAS)
        begin
            if (mantissa == 32'd0)
            begin
                rate = 32'd0;
            end
            else if (up_sh > 15'd32 || wide[63:32] != 32'd0)
            begin
                rate = 32'hFFFF_FFFF;
            end
            else
            begin
                rate = wide[31:0];
            end
        end
        else if (dn_sh > 15'd32)
        begin
            rate = 32'd0;
        end
        else
        begin
            rate = rounded[31:0];
        end
    end

endmodule

// ===== rtl/aiffsp_core.sv =====
`include "aiff_stream_parser_top_macros.svh"

// Chunk walker: advance the parse state by one file byte on each step and
// form the result that byte causes.
module aiffsp_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         byte_in,
    input  logic [15:0]        expected_channels,
    input  logic [31:0]        expected_rate,
    output logic               res_valid,
    output aiffsp_pkg::res_t   res
);

    aiffsp_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  field_count_reg, field_count_next;
    logic [31:0] field_accum_reg, field_accum_next;
    logic [31:0] comm_length_reg, comm_length_next;
    logic [15:0] rate_exponent_reg, rate_exponent_next;
    logic [31:0] file_rate_reg, file_rate_next;
    logic [1:0]  size_bytes_reg, size_bytes_next;
    logic [31:0] sound_left_reg, sound_left_next;
    logic [31:0] skip_count_reg, skip_count_next;
    logic        skip_pad_reg, skip_pad_next;
    logic [23:0] sample_accum_reg, sample_accum_next;
    logic [1:0]  sample_index_reg, sample_index_next;

    logic [31:0] field_word;
    logic [3:0]  count_inc;
    logic        field_done;
    logic [15:0] bits_val;
    logic [15:0] bits_round;
    logic        bits_bad;
    logic        chan_bad;
    logic [31:0] ssnd_len;
    logic [31:0] dec_rate;
    logic [23:0] acc_new;
    logic [1:0]  index_inc;
    logic        sample_done;
    logic [23:0] sample_ext;
    logic [31:0] left_after;
    logic        is_last;
    logic [31:0] skip_dec;
    logic        skip_pad_dec;

    assign field_word   = {field_accum_reg[23:0], byte_in};
    assign count_inc    = field_count_reg + 4'd1;
    assign field_done   = (count_inc == aiffsp_pkg::field_len(phase_reg));
    assign bits_val     = field_word[15:0];
    assign bits_round   = bits_val + 16'd7;
    assign bits_bad     = (bits_val < aiffsp_pkg::MIN_BITS) || (bits_val > aiffsp_pkg::MAX_BITS);
    assign chan_bad     = (field_word[15:0] != expected_channels);
    assign ssnd_len     = (field_word >= aiffsp_pkg::SSND_HDR_LEN)
                          ? field_word - aiffsp_pkg::SSND_HDR_LEN : 32'd0;
    assign acc_new      = {sample_accum_reg[15:0], byte_in};
    assign index_inc    = sample_index_reg + 2'd1;
    assign sample_done  = (index_inc == size_bytes_reg);
    assign left_after   = sound_left_reg - {30'd0, size_bytes_reg};
    assign is_last      = (left_after < {30'd0, size_bytes_reg});
    assign skip_dec     = (skip_count_reg != 32'd0) ? skip_count_reg - 32'd1 : 32'd0;
    assign skip_pad_dec = (skip_count_reg != 32'd0) ? skip_pad_reg : 1'b0;

    always_comb
    begin
        case (size_bytes_reg)
            2'd1:    sample_ext = {{16{acc_new[7]}}, acc_new[7:0]};
            2'd2:    sample_ext = {{8{acc_new[15]}}, acc_new[15:0]};
            default: sample_ext = acc_new;
        endcase
    end

    aiffsp_rate_dec u_rate_dec (
        .exponent (rate_exponent_reg),
        .mantissa (field_word),
        .rate     (dec_rate)
    );

    // Next state and datapath
    always_comb
    begin
        phase_next         = phase_reg;
        field_count_next   = field_count_reg;
        field_accum_next   = field_accum_reg;
        comm_length_next   = comm_length_reg;
        rate_exponent_next = rate_exponent_reg;
        file_rate_next     = file_rate_reg;
        size_bytes_next    = size_bytes_reg;
        sound_left_next    = sound_left_reg;
        skip_count_next    = skip_count_reg;
        skip_pad_next      = skip_pad_reg;
        sample_accum_next  = sample_accum_reg;
        sample_index_next  = sample_index_reg;

        case (phase_reg)
            aiffsp_pkg::PH_DONE, aiffsp_pkg::PH_HALT:
            begin
                phase_next = phase_reg;
            end
            aiffsp_pkg::PH_SKIP:
            begin
                skip_count_next = skip_dec;
                skip_pad_next   = skip_pad_dec;
                if (skip_dec == 32'd0 && !skip_pad_dec)
                begin
                    phase_next = aiffsp_pkg::PH_ID;
                end
            end
            aiffsp_pkg::PH_DATA:
            begin
                if (sample_done)
                begin
                    sample_accum_next = 24'd0;
                    sample_index_next = 2'd0;
                    sound_left_next   = left_after;
                    if (is_last)
                    begin
                        phase_next = aiffsp_pkg::PH_DONE;
                    end
                end
                else
                begin
                    sample_accum_next = acc_new;
                    sample_index_next = index_inc;
                end
            end
            default:
            begin
                if (!field_done)
                begin
                    field_accum_next = field_word;
                    field_count_next = count_inc;
                end
                else
                begin
                    field_accum_next = 32'd0;
                    field_count_next = 4'd0;
                    case (phase_reg)
                        aiffsp_pkg::PH_FORM:
                        begin
                            phase_next = (field_word != aiffsp_pkg::TAG_FORM)
                                         ? aiffsp_pkg::PH_HALT : aiffsp_pkg::PH_FORMLEN;
                        end
                        aiffsp_pkg::PH_FORMLEN:
                        begin
                            phase_next = aiffsp_pkg::PH_AIFF;
                        end
                        aiffsp_pkg::PH_AIFF:
                        begin
                            phase_next = (field_word != aiffsp_pkg::TAG_AIFF)
                                         ? aiffsp_pkg::PH_HALT : aiffsp_pkg::PH_ID;
                        end
                        aiffsp_pkg::PH_ID:
                        begin
                            if (field_word == aiffsp_pkg::TAG_SSND)
                            begin
                                phase_next = (size_bytes_reg == 2'd0)
                                             ? aiffsp_pkg::PH_HALT : aiffsp_pkg::PH_SSNDLEN;
                            end
                            else if (field_word == aiffsp_pkg::TAG_COMM)
                            begin
                                phase_next = aiffsp_pkg::PH_COMMLEN;
                            end
                            else
                            begin
                                phase_next = aiffsp_pkg::PH_LEN;
                            end
                        end
                        aiffsp_pkg::PH_LEN:
                        begin
                            skip_count_next = field_word;
                            skip_pad_next   = field_word[0];
                            phase_next      = (field_word == 32'd0)
                                              ? aiffsp_pkg::PH_ID : aiffsp_pkg::PH_SKIP;
                        end
                        aiffsp_pkg::PH_COMMLEN:
                        begin
                            comm_length_next = field_word;
                            phase_next       = aiffsp_pkg::PH_CHAN;
                        end
                        aiffsp_pkg::PH_CHAN:
                        begin
                            phase_next = chan_bad ? aiffsp_pkg::PH_HALT : aiffsp_pkg::PH_FRAMES;
                        end
                        aiffsp_pkg::PH_FRAMES:
                        begin
                            phase_next = aiffsp_pkg::PH_BITS;
                        end
                        aiffsp_pkg::PH_BITS:
                        begin
                            if (bits_bad)
                            begin
                                phase_next = aiffsp_pkg::PH_HALT;
                            end
                            else
                            begin
                                size_bytes_next = bits_round[4:3];
                                phase_next      = aiffsp_pkg::PH_EXP;
                            end
                        end
                        aiffsp_pkg::PH_EXP:
                        begin
                            rate_exponent_next = field_word[15:0];
                            phase_next         = aiffsp_pkg::PH_MANT;
                        end
                        aiffsp_pkg::PH_MANT:
                        begin
                            file_rate_next = dec_rate;
                            phase_next     = aiffsp_pkg::PH_MANTLO;
                        end
                        aiffsp_pkg::PH_MANTLO:
                        begin
                            if (comm_length_reg > aiffsp_pkg::COMM_STD_LEN)
                            begin
                                skip_count_next = comm_length_reg - aiffsp_pkg::COMM_STD_LEN;
                                skip_pad_next   = comm_length_reg[0];
                                phase_next      = aiffsp_pkg::PH_SKIP;
                            end
                            else
                            begin
                                phase_next = aiffsp_pkg::PH_ID;
                            end
                        end
                        aiffsp_pkg::PH_SSNDLEN:
                        begin
                            // Hold the usable byte count; trailing partial samples
                            // fall out when fewer than one sample is left.
                            sound_left_next = ssnd_len;
                            phase_next      = aiffsp_pkg::PH_OFFBLK;
                        end
                        aiffsp_pkg::PH_OFFBLK:
                        begin
                            sample_accum_next = 24'd0;
                            sample_index_next = 2'd0;
                            phase_next = (sound_left_reg >= {30'd0, size_bytes_reg})
                                         ? aiffsp_pkg::PH_DATA : aiffsp_pkg::PH_DONE;
                        end
                        default:
                        begin
                            phase_next = aiffsp_pkg::PH_HALT;
                        end
                    endcase
                end
            end
        endcase
    end

    // Result formation
    always_comb
    begin
        res_valid         = 1'b0;
        res.kind          = aiffsp_pkg::KIND_SAMPLE;
        res.sample        = 24'sd0;
        res.sample_bytes  = size_bytes_reg;
        res.file_rate     = 32'd0;
        res.rate_mismatch = 1'b0;
        res.error_code    = aiffsp_pkg::ERR_NONE;
        res.last          = 1'b0;

        case (phase_reg)
            aiffsp_pkg::PH_FORM:
            begin
                if (field_done && field_word != aiffsp_pkg::TAG_FORM)
                begin
                    res_valid      = 1'b1;
                    res.kind       = aiffsp_pkg::KIND_ERROR;
                    res.error_code = aiffsp_pkg::ERR_NO_FORM;
                end
            end
            aiffsp_pkg::PH_AIFF:
            begin
                if (field_done && field_word != aiffsp_pkg::TAG_AIFF)
                begin
                    res_valid      = 1'b1;
                    res.kind       = aiffsp_pkg::KIND_ERROR;
                    res.error_code = aiffsp_pkg::ERR_NOT_AIFF;
                end
            end
            aiffsp_pkg::PH_ID:
            begin
                if (field_done && field_word == aiffsp_pkg::TAG_SSND && size_bytes_reg == 2'd0)
                begin
                    res_valid      = 1'b1;
                    res.kind       = aiffsp_pkg::KIND_ERROR;
                    res.error_code = aiffsp_pkg::ERR_DATA_EARLY;
                end
            end
            aiffsp_pkg::PH_CHAN:
            begin
                if (field_done && chan_bad)
                begin
                    res_valid      = 1'b1;
                    res.kind       = aiffsp_pkg::KIND_ERROR;
                    res.error_code = aiffsp_pkg::ERR_CHANNELS;
                end
            end
            aiffsp_pkg::PH_BITS:
            begin
                if (field_done && bits_bad)
                begin
                    res_valid      = 1'b1;
                    res.kind       = aiffsp_pkg::KIND_ERROR;
                    res.error_code = aiffsp_pkg::ERR_BITS;
                end
            end
            aiffsp_pkg::PH_MANT:
            begin
                if (field_done)
                begin
                    res_valid         = 1'b1;
                    res.kind          = aiffsp_pkg::KIND_FORMAT;
                    res.file_rate     = dec_rate;
                    res.rate_mismatch = (dec_rate != expected_rate);
                end
            end
            aiffsp_pkg::PH_DATA:
            begin
                if (sample_done)
                begin
                    res_valid         = 1'b1;
                    res.kind          = aiffsp_pkg::KIND_SAMPLE;
                    res.sample        = sample_ext;
                    res.file_rate     = file_rate_reg;
                    res.rate_mismatch = (file_rate_reg != expected_rate);
                    res.last          = is_last;
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= aiffsp_pkg::PH_FORM;
            field_count_reg   <= 4'd0;
            field_accum_reg   <= 32'd0;
            comm_length_reg   <= 32'd0;
            rate_exponent_reg <= 16'd0;
            file_rate_reg     <= 32'd0;
            size_bytes_reg    <= 2'd0;
            sound_left_reg    <= 32'd0;
            skip_count_reg    <= 32'd0;
            skip_pad_reg      <= 1'b0;
            sample_accum_reg  <= 24'd0;
            sample_index_reg  <= 2'd0;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            field_count_reg   <= field_count_next;
            field_accum_reg   <= field_accum_next;
            comm_length_reg   <= comm_length_next;
            rate_exponent_reg <= rate_exponent_next;
            file_rate_reg     <= file_rate_next;
            size_bytes_reg    <= size_bytes_next;
            sound_left_reg    <= sound_left_next;
            skip_count_reg    <= skip_count_next;
            skip_pad_reg      <= skip_pad_next;
            sample_accum_reg  <= sample_accum_next;
            sample_index_reg  <= sample_index_next;
        end
    end

    `AIFFSP_ASSERT_NEXT(a_halt_sticky, clk, rst_n, phase_reg == aiffsp_pkg::PH_HALT, phase_reg == aiffsp_pkg::PH_HALT)
    `AIFFSP_ASSERT_NEXT(a_error_halts, clk, rst_n, step && res_valid && res.kind == aiffsp_pkg::KIND_ERROR, phase_reg == aiffsp_pkg::PH_HALT)
    `AIFFSP_ASSERT(a_data_in_range, clk, rst_n, phase_reg == aiffsp_pkg::PH_DATA, sample_index_reg < size_bytes_reg && sound_left_reg >= {30'd0, size_bytes_reg})
    `AIFFSP_ASSERT(a_sample_from_data, clk, rst_n, res_valid && res.kind == aiffsp_pkg::KIND_SAMPLE, phase_reg == aiffsp_pkg::PH_DATA)

endmodule

// ===== rtl/aiff_stream_parser_top.sv =====
// AIFF stream parser. Feed the file one byte per item on the input channel;
// the block checks the FORM and AIFF tags, skips unknown chunks (plus a pad
// byte on odd lengths), reports each COMM format it reads (kind 1, with the
// rounded and saturated rate and a mismatch flag against expected_rate),
// then emits each SSND sample sign-extended to 24 bits (kind 0), flagging the
// final one with last. Any error gives one kind 2 item with its code and the
// block then ignores all bytes until reset; after the last sample the rest
// of the file is ignored too. Rate: one byte per cycle while results are
// taken. A byte is held in the input register and processed when the parser
// advances; its result, if it has one, then enters the result register,
// which drives out_valid. While a result waits for out_ready the
// parser does not advance: the byte behind it stays in the input register,
// and once that register is full in_ready drops, so at most one more byte is
// taken during a stall. There is no clearing pass after reset. Write
// expected_channels (index 0) and expected_rate (index 1) only while no byte
// is in flight; the config port is always ready, and writes to other indexes
// are dropped.
module aiff_stream_parser_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [7:0]                           file_byte,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [1:0]                           kind,
    output logic signed [23:0]                   sample,
    output logic [1:0]                           sample_bytes,
    output logic [31:0]                          file_rate,
    output logic                                 rate_mismatch,
    output logic [2:0]                           error_code,
    output logic                                 last,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [aiffsp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [31:0]                          cfg_data
);

    logic               in_valid_reg, in_valid_next;
    logic [7:0]         in_byte_reg;
    logic               out_valid_reg, out_valid_next;
    aiffsp_pkg::res_t   out_res_reg;
    logic [15:0]        exp_channels_reg;
    logic [31:0]        exp_rate_reg;
    logic               advance;
    logic               res_valid;
    aiffsp_pkg::res_t   res;

    // Process the held byte whenever the result register is free or draining
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign in_valid_next  = (in_valid && in_ready) || (in_valid_reg && !advance);
    assign out_valid_next = advance ? res_valid : (out_valid_reg && !out_ready);

    aiffsp_core u_core (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (advance),
        .byte_in           (in_byte_reg),
        .expected_channels (exp_channels_reg),
        .expected_rate     (exp_rate_reg),
        .res_valid         (res_valid),
        .res               (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            exp_channels_reg <= 16'd1;
            exp_rate_reg     <= 32'd44100;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == aiffsp_pkg::CFG_EXP_CHANNELS)
                begin
                    exp_channels_reg <= cfg_data[15:0];
                end
                else if (cfg_index == aiffsp_pkg::CFG_EXP_RATE)
                begin
                    exp_rate_reg <= cfg_data;
                end
            end
        end
    end

    // Payload registers: load on their handshakes, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= file_byte;
        end
        if (advance && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = out_res_reg.kind;
    assign sample        = out_res_reg.sample;
    assign sample_bytes  = out_res_reg.sample_bytes;
    assign file_rate     = out_res_reg.file_rate;
    assign rate_mismatch = out_res_reg.rate_mismatch;
    assign error_code    = out_res_reg.error_code;
    assign last          = out_res_reg.last;

endmodule
